// ===== hw/rtl/adpcm_fifo_sound_registers_unit_defines.svh =====
// assertion macros for the sound register unit
`ifndef ADPCM_FIFO_SOUND_REGISTERS_UNIT_DEFINES_SVH
`define ADPCM_FIFO_SOUND_REGISTERS_UNIT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define AFSR_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sound register unit check failed");

// condition must hold in the cycle after the trigger
`define AFSR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sound register unit check failed");

`endif

// ===== hw/rtl/adpcm_fsr_pkg.sv =====
// shared types, constants and tables for the sound register unit
`timescale 1ns / 1ps

package adpcm_fsr_pkg;

   // fifo geometry
   localparam int FifoDepth     = 256;
   localparam int FifoPtrWidth  = $clog2(FifoDepth);
   localparam int FifoFillWidth = $clog2(FifoDepth + 1);

   // item kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // register map
   localparam logic [2:0] REG_ADDR    = 3'd0;
   localparam logic [2:0] REG_FM_DATA = 3'd1;
   localparam logic [2:0] REG_FIFO    = 3'd2;
   localparam logic [2:0] REG_CTRL    = 3'd3;
   localparam logic [2:0] REG_LVOL    = 3'd4;
   localparam logic [2:0] REG_RVOL    = 3'd5;
   localparam logic [2:0] REG_ID      = 3'd6;
   localparam logic [2:0] REG_VERSION = 3'd7;

   // register values and bits
   localparam logic [7:0] CtrlReset      = 8'h03;
   localparam logic [7:0] VolReset       = 8'h80;
   localparam logic [3:0] GainReset      = 4'd8;
   localparam logic [7:0] ChipId         = 8'h51;
   localparam logic [7:0] ChipVersion    = 8'h04;
   localparam logic [7:0] StatusNotFull  = 8'h40;
   localparam logic [7:0] StatusPlaying  = 8'h20;
   localparam logic [7:0] ReadUnmapped   = 8'hFF;
   localparam int         CtrlPlayBit    = 3;

   // decoder constants
   localparam int                 RateWidth     = 18;
   localparam logic [17:0]        RateReset     = 18'd48000;
   localparam logic [17:0]        PhaseStep     = 18'd15625;
   localparam logic [5:0]         StepIndexMax  = 6'd48;
   localparam logic signed [13:0] PredMax       = 14'sd2047;
   localparam logic signed [13:0] PredMin       = -14'sd2048;

   // one request in
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] reg_index;
      logic [7:0] write_value;
   } req_type;

   // one response out
   typedef struct packed {
      logic [7:0]         read_data;
      logic               fm_write_strobe;
      logic [7:0]         fm_address;
      logic [7:0]         fm_data;
      logic signed [15:0] pcm_sample;
      logic               playing;
   } rsp_type;

   // sequencer states
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_EXEC  = 9'b000000010,
      ST_LOOP  = 9'b000000100,
      ST_FETCH = 9'b000001000,
      ST_DELTA = 9'b000010000,
      ST_PRED  = 9'b000100000,
      ST_MUL   = 9'b001000000,
      ST_SCALE = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   // adpcm step size for a step index
   function automatic logic [10:0] step_value(input logic [5:0] idx);
      logic [10:0] s;
      unique case (idx)
         6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
         6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
         6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
         6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
         6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
         6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
         6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
         6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
         6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
         6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
         6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
         6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
         6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
         6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
         6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
         6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
         default: s = 11'd1552;
      endcase
      return s;
   endfunction

   // output gain for a gain select code
   function automatic logic [13:0] gain_value(input logic [3:0] sel);
      logic [13:0] g;
      unique case (sel)
         4'd0:  g = 14'd267;   4'd1:  g = 14'd410;   4'd2:  g = 14'd492;
         4'd3:  g = 14'd656;   4'd4:  g = 14'd799;   4'd5:  g = 14'd1045;
         4'd6:  g = 14'd1270;  4'd7:  g = 14'd1536;  4'd8:  g = 14'd2048;
         4'd9:  g = 14'd2479;  4'd10: g = 14'd2991;  4'd11: g = 14'd3994;
         4'd12: g = 14'd5325;  4'd13: g = 14'd6431;  4'd14: g = 14'd8561;
         default: g = 14'd10363;
      endcase
      return g;
   endfunction

endpackage

// ===== hw/rtl/adpcm_fifo_sound_registers_unit.sv =====
// sound expansion registers with adpcm sample fifo and nibble decoder
`timescale 1ns / 1ps
`include "adpcm_fifo_sound_registers_unit_defines.svh"

// Register, FIFO and ADPCM playback block. Each request (register write,
// register read or host sample tick) gives exactly one response carrying the
// read byte, any FM write forwarded, the current 16-bit sample and the play
// flag. A write, a read, or a tick that decodes nothing passes the execute
// and done states before its response is loaded. A tick during playback
// decodes up to two nibbles, each via loop, fetch, delta, predictor, multiply
// and scale states, a slot that finds the fifo empty only via loop and fetch;
// each decode walks one shared datapath: fifo read, step delta, predictor
// update, gain multiply, scaling. One request is taken at a time; the block
// is ready again once the response is loaded into the output register, which
// waits while rsp_stall holds an earlier one. A finished response sits there
// so the next request can be accepted while it waits. The sample rate
// register may be written at any time the block is idle and is always ready.
module adpcm_fifo_sound_registers_unit
   import adpcm_fsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // sample rate register
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [RateWidth-1:0] csr_data
);

   // control and register state
   state_type                 state_ff, state_in;
   req_type                   req_ff, req_in;
   logic [RateWidth-1:0]      rate_ff;
   logic [7:0]                addr_latch_ff, addr_latch_in;
   logic [7:0]                control_ff, control_in;
   logic [7:0]                lvol_ff, lvol_in;
   logic [7:0]                rvol_ff, rvol_in;
   logic [3:0]                gain_sel_ff, gain_sel_in;
   logic [FifoPtrWidth-1:0]   fifo_rd_ptr_ff, fifo_rd_ptr_in;
   logic [FifoPtrWidth-1:0]   fifo_wr_ptr_ff, fifo_wr_ptr_in;
   logic [FifoFillWidth-1:0]  fifo_fill_ff, fifo_fill_in;
   logic                      active_ff, active_in;
   logic                      high_nib_ff, high_nib_in;
   logic signed [11:0]        predictor_ff, predictor_in;
   logic [5:0]                step_index_ff, step_index_in;
   logic [RateWidth-1:0]      phase_ff, phase_in;
   logic signed [15:0]        sample_ff, sample_in;

   // working registers of the sequencer
   logic [RateWidth:0]        phase_sum_ff, phase_sum_in;
   logic [1:0]                slot_cnt_ff, slot_cnt_in;
   logic [3:0]                code_ff, code_in;
   logic [11:0]               delta_ff, delta_in;
   logic signed [26:0]        prod_ff, prod_in;
   logic [7:0]                res_rd_ff, res_rd_in;
   logic                      res_strobe_ff, res_strobe_in;
   logic [7:0]                res_fa_ff, res_fa_in;
   logic [7:0]                res_fd_ff, res_fd_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   // fifo memory
   logic [7:0]                fifo_mem [FifoDepth];
   logic [7:0]                fifo_rdata_ff;
   logic                      fifo_push;

   // combinational helpers
   logic                      accept;
   logic                      fifo_full;
   logic                      phase_geq;
   logic [10:0]               step;
   logic [3:0]                code;
   logic signed [13:0]        pred_sum;
   logic signed [6:0]         idx_sum;
   logic signed [6:0]         idx_adj;
   logic                      play_was;
   logic                      play_will;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign fifo_full = (fifo_fill_ff == FifoFillWidth'(FifoDepth));
   assign phase_geq = (phase_sum_ff >= {1'b0, rate_ff});
   assign fifo_push = (state_ff == ST_EXEC) && (req_ff.kind == KIND_WRITE) &&
                      (req_ff.reg_index == REG_FIFO) && !fifo_full;

   // sequencer and datapath next state
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      addr_latch_in  = addr_latch_ff;
      control_in     = control_ff;
      lvol_in        = lvol_ff;
      rvol_in        = rvol_ff;
      gain_sel_in    = gain_sel_ff;
      fifo_rd_ptr_in = fifo_rd_ptr_ff;
      fifo_wr_ptr_in = fifo_wr_ptr_ff;
      fifo_fill_in   = fifo_fill_ff;
      active_in      = active_ff;
      high_nib_in    = high_nib_ff;
      predictor_in   = predictor_ff;
      step_index_in  = step_index_ff;
      phase_in       = phase_ff;
      sample_in      = sample_ff;
      phase_sum_in   = phase_sum_ff;
      slot_cnt_in    = slot_cnt_ff;
      code_in        = code_ff;
      delta_in       = delta_ff;
      prod_in        = prod_ff;
      res_rd_in      = res_rd_ff;
      res_strobe_in  = res_strobe_ff;
      res_fa_in      = res_fa_ff;
      res_fd_in      = res_fd_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      step      = step_value(step_index_ff);
      code      = high_nib_ff ? fifo_rdata_ff[7:4] : fifo_rdata_ff[3:0];
      pred_sum  = code_ff[3] ? (14'(predictor_ff) - $signed({2'b00, delta_ff}))
                             : (14'(predictor_ff) + $signed({2'b00, delta_ff}));
      play_was  = control_ff[CtrlPlayBit];
      play_will = req_ff.write_value[CtrlPlayBit];

      // step index adjustment from the low three code bits
      unique case (code_ff[2:0])
         3'd4:    idx_adj = 7'sd2;
         3'd5:    idx_adj = 7'sd4;
         3'd6:    idx_adj = 7'sd6;
         3'd7:    idx_adj = 7'sd8;
         default: idx_adj = -7'sd1;
      endcase
      idx_sum = $signed({1'b0, step_index_ff}) + idx_adj;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end

         // register access or tick set-up
         ST_EXEC: begin
            res_rd_in     = '0;
            res_strobe_in = 1'b0;
            res_fa_in     = '0;
            res_fd_in     = '0;
            state_in      = ST_DONE;
            unique case (req_ff.kind)
               KIND_WRITE: begin
                  unique case (req_ff.reg_index)
                     REG_ADDR: addr_latch_in = req_ff.write_value;
                     REG_FM_DATA: begin
                        res_strobe_in = 1'b1;
                        res_fa_in     = addr_latch_ff;
                        res_fd_in     = req_ff.write_value;
                     end
                     REG_FIFO: begin
                        if (!fifo_full) begin
                           fifo_wr_ptr_in = (fifo_wr_ptr_ff == FifoPtrWidth'(FifoDepth - 1))
                                            ? '0 : fifo_wr_ptr_ff + 1'b1;
                           fifo_fill_in   = fifo_fill_ff + 1'b1;
                        end
                     end
                     REG_CTRL: begin
                        control_in  = req_ff.write_value;
                        gain_sel_in = req_ff.write_value[7:4];
                        if (!play_was && play_will) begin
                           active_in     = 1'b1;
                           predictor_in  = '0;
                           step_index_in = '0;
                           phase_in      = '0;
                           sample_in     = '0;
                        end
                        if (play_was && !play_will) begin
                           active_in      = 1'b0;
                           sample_in      = '0;
                           fifo_rd_ptr_in = '0;
                           fifo_wr_ptr_in = '0;
                           fifo_fill_in   = '0;
                           high_nib_in    = 1'b0;
                        end
                     end
                     REG_LVOL: lvol_in = req_ff.write_value;
                     REG_RVOL: rvol_in = req_ff.write_value;
                     default: ;
                  endcase
               end
               KIND_READ: begin
                  unique case (req_ff.reg_index)
                     REG_ADDR:    res_rd_in = addr_latch_ff;
                     REG_FIFO:    res_rd_in = (fifo_full ? 8'h00 : StatusNotFull) |
                                              (active_ff ? StatusPlaying : 8'h00);
                     REG_CTRL:    res_rd_in = control_ff;
                     REG_LVOL:    res_rd_in = lvol_ff;
                     REG_RVOL:    res_rd_in = rvol_ff;
                     REG_ID:      res_rd_in = ChipId;
                     REG_VERSION: res_rd_in = ChipVersion;
                     default:     res_rd_in = ReadUnmapped;
                  endcase
               end
               KIND_TICK: begin
                  if (rate_ff == '0) begin
                     sample_in = '0;
                  end else if (active_ff) begin
                     phase_sum_in = {1'b0, phase_ff} + {1'b0, PhaseStep};
                     slot_cnt_in  = '0;
                     state_in     = ST_LOOP;
                  end
               end
               default: ;
            endcase
         end

         // shared compare and subtract of the phase accumulator
         ST_LOOP: begin
            if (phase_geq && (slot_cnt_ff != 2'd2)) begin
               phase_sum_in = phase_sum_ff - {1'b0, rate_ff};
               slot_cnt_in  = slot_cnt_ff + 1'b1;
               state_in     = ST_FETCH;
            end else begin
               phase_in = phase_geq ? (rate_ff - 1'b1) : phase_sum_ff[RateWidth-1:0];
               state_in = ST_DONE;
            end
         end

         // empty fifo stops playback, else the byte is read
         ST_FETCH: begin
            if (fifo_fill_ff == '0) begin
               active_in   = 1'b0;
               high_nib_in = 1'b0;
               sample_in   = '0;
               state_in    = ST_LOOP;
            end else begin
               state_in = ST_DELTA;
            end
         end

         // pick the nibble and form the delta
         ST_DELTA: begin
            code_in  = code;
            delta_in = 12'(step >> 3)
                     + (code[0] ? 12'(step >> 2) : 12'd0)
                     + (code[1] ? 12'(step >> 1) : 12'd0)
                     + (code[2] ? 12'(step) : 12'd0);
            if (high_nib_ff) begin
               fifo_rd_ptr_in = (fifo_rd_ptr_ff == FifoPtrWidth'(FifoDepth - 1))
                                ? '0 : fifo_rd_ptr_ff + 1'b1;
               fifo_fill_in   = fifo_fill_ff - 1'b1;
            end
            high_nib_in = !high_nib_ff;
            state_in    = ST_PRED;
         end

         // predictor and step index update with clamping
         ST_PRED: begin
            if (pred_sum > PredMax) begin
               predictor_in = 12'(PredMax);
            end else if (pred_sum < PredMin) begin
               predictor_in = 12'(PredMin);
            end else begin
               predictor_in = pred_sum[11:0];
            end
            if (idx_sum < 7'sd0) begin
               step_index_in = '0;
            end else if (idx_sum > $signed({1'b0, StepIndexMax})) begin
               step_index_in = StepIndexMax;
            end else begin
               step_index_in = idx_sum[5:0];
            end
            state_in = ST_MUL;
         end

         // gain multiply
         ST_MUL: begin
            prod_in  = 27'(predictor_ff) * 27'($signed({1'b0, gain_value(gain_sel_ff)}));
            state_in = ST_SCALE;
         end

         // divide by 1024 rounding towards minus infinity, always in range
         ST_SCALE: begin
            sample_in = prod_ff[25:10];
            state_in  = ST_LOOP;
         end

         // hand the response to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.read_data       = res_rd_ff;
               rsp_in.fm_write_strobe = res_strobe_ff;
               rsp_in.fm_address      = res_fa_ff;
               rsp_in.fm_data         = res_fd_ff;
               rsp_in.pcm_sample      = sample_ff;
               rsp_in.playing         = active_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rate_ff        <= RateReset;
         addr_latch_ff  <= '0;
         control_ff     <= CtrlReset;
         lvol_ff        <= VolReset;
         rvol_ff        <= VolReset;
         gain_sel_ff    <= GainReset;
         fifo_rd_ptr_ff <= '0;
         fifo_wr_ptr_ff <= '0;
         fifo_fill_ff   <= '0;
         active_ff      <= 1'b0;
         high_nib_ff    <= 1'b0;
         predictor_ff   <= '0;
         step_index_ff  <= '0;
         phase_ff       <= '0;
         sample_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         if (csr_valid && csr_ready) begin
            rate_ff <= csr_data;
         end
         addr_latch_ff  <= addr_latch_in;
         control_ff     <= control_in;
         lvol_ff        <= lvol_in;
         rvol_ff        <= rvol_in;
         gain_sel_ff    <= gain_sel_in;
         fifo_rd_ptr_ff <= fifo_rd_ptr_in;
         fifo_wr_ptr_ff <= fifo_wr_ptr_in;
         fifo_fill_ff   <= fifo_fill_in;
         active_ff      <= active_in;
         high_nib_ff    <= high_nib_in;
         predictor_ff   <= predictor_in;
         step_index_ff  <= step_index_in;
         phase_ff       <= phase_in;
         sample_ff      <= sample_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      phase_sum_ff  <= phase_sum_in;
      slot_cnt_ff   <= slot_cnt_in;
      code_ff       <= code_in;
      delta_ff      <= delta_in;
      prod_ff       <= prod_in;
      res_rd_ff     <= res_rd_in;
      res_strobe_ff <= res_strobe_in;
      res_fa_ff     <= res_fa_in;
      res_fd_ff     <= res_fd_in;
      rsp_ff        <= rsp_in;
   end

   // sample fifo storage, registered read
   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem[fifo_wr_ptr_ff] <= req_ff.write_value;
      end
      if (state_ff == ST_FETCH) begin
         fifo_rdata_ff <= fifo_mem[fifo_rd_ptr_ff];
      end
   end

   // checks
   `AFSR_ASSERT_IMPLIES(a_fifo_fill_bound, clock, reset, 1'b1, fifo_fill_ff <= FifoFillWidth'(FifoDepth))
   `AFSR_ASSERT_IMPLIES(a_fifo_empty_ptrs, clock, reset, fifo_fill_ff == '0, fifo_rd_ptr_ff == fifo_wr_ptr_ff)
   `AFSR_ASSERT_IMPLIES(a_step_index_range, clock, reset, 1'b1, step_index_ff <= StepIndexMax)
   `AFSR_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall, state_ff == ST_EXEC)

endmodule
